// File: src/pgdb_pkg.sv
// Shared types, codes and constants of the polar grid descriptor binner.
package pgdb_pkg;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_SQUARE, ST_RANGE, ST_CORDIC, ST_RING, ST_SECTOR,
      ST_ADDR, ST_LOOKUP, ST_UPDATE, ST_SCALE, ST_RESULT, ST_CLEAR
   } state_type;

   // Request command codes
   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // Register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_RINGS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SECTORS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RADIUS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COMBINE_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_RECIP = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_VALUE = 3'd5;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int COORD_W  = 16;
   localparam int INTEN_W  = 16;
   localparam int RSEL_W   = 6;
   localparam int SSEL_W   = 7;
   localparam int CELL_W   = 32;
   localparam int OUT_W    = 48;

   // Angle arithmetic: a full turn is 2^32
   localparam int CORDIC_STEPS = 24;
   localparam int CPW          = 42;   // CORDIC vector width, signed
   localparam int ZW           = 34;   // angle accumulator width, signed
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [CELL_W-1:0] CELL_MAX = '1;
   localparam logic [OUT_W-1:0]  OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};

   // atan(2^-i) as a fraction of a full turn
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:  a = 32'h2000_0000;
         5'd1:  a = 32'h12E4_051E;
         5'd2:  a = 32'h09FB_385B;
         5'd3:  a = 32'h0511_11D4;
         5'd4:  a = 32'h028B_0D43;
         5'd5:  a = 32'h0145_D7E1;
         5'd6:  a = 32'h00A2_F61E;
         5'd7:  a = 32'h0051_7C55;
         5'd8:  a = 32'h0028_BE53;
         5'd9:  a = 32'h0014_5F2F;
         5'd10: a = 32'h000A_2F98;
         5'd11: a = 32'h0005_17CC;
         5'd12: a = 32'h0002_8BE6;
         5'd13: a = 32'h0001_45F3;
         5'd14: a = 32'h0000_A2F9;
         5'd15: a = 32'h0000_517C;
         5'd16: a = 32'h0000_28BE;
         5'd17: a = 32'h0000_145F;
         5'd18: a = 32'h0000_0A2F;
         5'd19: a = 32'h0000_0517;
         5'd20: a = 32'h0000_028B;
         5'd21: a = 32'h0000_0145;
         5'd22: a = 32'h0000_00A2;
         5'd23: a = 32'h0000_0051;
         default: a = 32'h0;
      endcase
      return a;
   endfunction

endpackage

// File: src/pgdb_if.sv
// Request and response channel interfaces of the binner.
interface pgdb_req_if import pgdb_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic signed [COORD_W-1:0] x;
   logic signed [COORD_W-1:0] y;
   logic [INTEN_W-1:0]        intensity;
   logic [RSEL_W-1:0]         ring_sel;
   logic [SSEL_W-1:0]         sector_sel;

   modport source (output valid, cmd, x, y, intensity, ring_sel, sector_sel, input ready);
   modport sink   (input valid, cmd, x, y, intensity, ring_sel, sector_sel, output ready);
endinterface

interface pgdb_rsp_if import pgdb_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] cell_value;
   logic                    cell_empty;

   modport source (output valid, cell_value, cell_empty, input ready);
   modport sink   (input valid, cell_value, cell_empty, output ready);
endinterface

// File: src/pgdb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pgdb_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 8192
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

// File: src/polar_grid_descriptor_binner.sv
// Polar grid descriptor binner: top level with sequencer, CORDIC and cell memory.
// Add point: square, range check, CORDIC steps, ring search (one ring compare per cycle),
// sector, address, lookup and update; a point beyond the radius ends at the range check.
// Read cell: lookup, scale and result, response registered; clear: a sweep over all cells.
// One request at a time, taken only when idle; CORDIC and ring search set the rate. Reset is
// synchronous; then all cells are cleared before any request (register writes always taken).
module polar_grid_descriptor_binner import pgdb_pkg::*; #(
   parameter int MAX_RINGS   = 64,
   parameter int MAX_SECTORS = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   pgdb_req_if.sink              req_ch,
   pgdb_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int NUM_CELLS = MAX_RINGS * MAX_SECTORS;
   localparam int AW  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int RW  = $clog2(MAX_RINGS + 1);
   localparam int SW  = $clog2(MAX_SECTORS + 1);
   localparam int TW  = 32 + 2 * RW;
   localparam int SPW = 32 + SW;
   localparam int WW  = CELL_W + 1;
   localparam logic [AW-1:0] LAST_CELL = AW'(NUM_CELLS - 1);

   // Configuration registers
   logic [6:0]             num_rings_ff;
   logic [7:0]             num_sectors_ff;
   logic [14:0]            max_radius_ff;
   logic                   combine_max_ff;
   logic [15:0]            scale_recip_ff;
   logic [CSR_DATA_W-1:0]  empty_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rings_ff   <= 7'd20;
         num_sectors_ff <= 8'd60;
         max_radius_ff  <= 15'd1280;
         combine_max_ff <= 1'b0;
         scale_recip_ff <= 16'd256;
         empty_value_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_RINGS:   num_rings_ff   <= csr_wdata[6:0];
            CSR_NUM_SECTORS: num_sectors_ff <= csr_wdata[7:0];
            CSR_MAX_RADIUS:  max_radius_ff  <= csr_wdata[14:0];
            CSR_COMBINE_MAX: combine_max_ff <= csr_wdata[0];
            CSR_SCALE_RECIP: scale_recip_ff <= csr_wdata[15:0];
            CSR_EMPTY_VALUE: empty_value_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective grid size and radius
   logic [RW-1:0] rings_eff;
   logic [SW-1:0] sectors_eff;
   logic [14:0]   radius_eff;

   always_comb begin
      if (num_rings_ff == 7'd0)                  rings_eff = RW'(1);
      else if (32'(num_rings_ff) > MAX_RINGS)    rings_eff = RW'(MAX_RINGS);
      else                                       rings_eff = RW'(num_rings_ff);
      if (num_sectors_ff == 8'd0)                sectors_eff = SW'(1);
      else if (32'(num_sectors_ff) > MAX_SECTORS) sectors_eff = SW'(MAX_SECTORS);
      else                                       sectors_eff = SW'(num_sectors_ff);
      radius_eff = (max_radius_ff == 15'd0) ? 15'd1 : max_radius_ff;
   end

   // Squares of the configuration, refreshed every cycle
   logic [29:0]     mr2_ff;
   logic [2*RW-1:0] rr2_ff;

   always_ff @(posedge clock) begin
      mr2_ff <= radius_eff * radius_eff;
      rr2_ff <= rings_eff * rings_eff;
   end

   // Sequencer
   state_type state_ff, state_in;
   logic      accept;
   logic      ring_done;
   logic      out_free;
   logic      is_read_ff;
   logic [AW-1:0] cnt_ff;
   logic [4:0]    step_ff;
   logic [RW-1:0] k_ff;
   logic [31:0]   r2;

   assign accept   = req_ch.valid & req_ch.ready;
   assign out_free = !rsp_ch.valid || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: if (cnt_ff == LAST_CELL) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd_type'(req_ch.cmd))
                  CMD_ADD:   state_in = ST_SQUARE;
                  CMD_READ:  state_in = ST_LOOKUP;
                  CMD_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SQUARE:  state_in = ST_RANGE;
         ST_RANGE:   state_in = (r2 > 32'(mr2_ff)) ? ST_IDLE : ST_CORDIC;
         ST_CORDIC:  if (step_ff == 5'(CORDIC_STEPS - 1)) state_in = ST_RING;
         ST_RING:    if (ring_done) state_in = ST_SECTOR;
         ST_SECTOR:  state_in = ST_ADDR;
         ST_ADDR:    state_in = ST_LOOKUP;
         ST_LOOKUP:  state_in = is_read_ff ? ST_SCALE : ST_UPDATE;
         ST_UPDATE:  state_in = ST_IDLE;
         ST_SCALE:   state_in = ST_RESULT;
         ST_RESULT:  if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_INIT;
      else       state_ff <= state_in;
   end

   // Memory control outputs of the sequencer
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [WW-1:0] ram_wdata;
   logic [WW-1:0] ram_rdata;
   logic [WW-1:0] upd_word;
   logic [AW-1:0] addr_ff;
   logic          out_load;

   always_comb begin
      req_ch.ready = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = upd_word;
      out_load     = 1'b0;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = '0;
         end
         ST_IDLE:   req_ch.ready = 1'b1;
         ST_UPDATE: ram_we = 1'b1;
         ST_RESULT: out_load = out_free;
         default: ;
      endcase
   end

   // Sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (state_ff == ST_INIT || state_ff == ST_CLEAR) begin
         cnt_ff <= (cnt_ff == LAST_CELL) ? '0 : cnt_ff + 1'b1;
      end
   end

   // Request capture
   logic signed [COORD_W-1:0] x_ff, y_ff;
   logic [INTEN_W-1:0]        inten_ff;
   logic                      inrange_ff;
   logic [31:0]               rd_addr;

   assign rd_addr = 32'(req_ch.ring_sel) * 32'(MAX_SECTORS) + 32'(req_ch.sector_sel);

   // Point geometry
   logic [31:0]  xx_ff, yy_ff;
   logic [TW-1:0] target_ff, sq_ff, dsq_ff;
   logic [16:0]  ax, ay;
   logic signed [CPW-1:0] px_ff, py_ff, px_sh, py_sh;
   logic signed [ZW-1:0]  z_ff, atan_s;
   logic [31:0]  phi, angle;
   logic [47:0]  mul_ff;
   logic [SPW:0] sec_sum;
   logic [SW:0]  sec_raw;
   logic [SW-1:0] sec;
   logic [RW-1:0] ring_m1;
   logic [SW-1:0] sec_m1;
   logic [31:0]  pt_addr;

   assign r2        = xx_ff + yy_ff;
   assign ring_done = (sq_ff >= target_ff) || (k_ff == rings_eff);
   assign ax        = x_ff[COORD_W-1] ? 17'(-32'(x_ff)) : 17'(x_ff);
   assign ay        = y_ff[COORD_W-1] ? 17'(-32'(y_ff)) : 17'(y_ff);
   assign px_sh     = px_ff >>> step_ff;
   assign py_sh     = py_ff >>> step_ff;
   assign atan_s    = ZW'(atan_turn(step_ff));

   // First-quadrant angle with axis cases and clamp, then quadrant fold
   always_comb begin
      if (ay == 17'd0)           phi = 32'd0;
      else if (ax == 17'd0)      phi = QUARTER_TURN;
      else if (z_ff < 0)         phi = 32'd0;
      else if (z_ff > ZW'(QUARTER_TURN)) phi = QUARTER_TURN;
      else                       phi = z_ff[31:0];
      case ({x_ff[COORD_W-1], y_ff[COORD_W-1]})
         2'b00:   angle = phi;
         2'b10:   angle = HALF_TURN - phi;
         2'b11:   angle = HALF_TURN + phi;
         default: angle = 32'd0 - phi;
      endcase
   end

   // Sector from the registered angle product, clamped to 1..S
   assign sec_sum = (SPW+1)'(mul_ff[SPW-1:0]) + (SPW+1)'(32'hFFFF_FFFF);
   assign sec_raw = sec_sum[SPW:32];
   always_comb begin
      if (sec_raw == '0)                  sec = SW'(1);
      else if (sec_raw > (SW+1)'(sectors_eff)) sec = sectors_eff;
      else                                sec = SW'(sec_raw);
   end
   assign ring_m1 = k_ff - 1'b1;
   assign sec_m1  = sec - 1'b1;
   assign pt_addr = 32'(ring_m1) * 32'(MAX_SECTORS) + 32'(sec_m1);

   // Cell update: first point stores, later ones sum with saturation or keep max
   logic [CELL_W:0]   sum33;
   logic [CELL_W-1:0] inten_w;
   assign inten_w = CELL_W'(inten_ff);
   assign sum33   = {1'b0, ram_rdata[CELL_W-1:0]} + {1'b0, inten_w};
   always_comb begin
      if (!ram_rdata[CELL_W])
         upd_word = {1'b1, inten_w};
      else if (combine_max_ff)
         upd_word = {1'b1, (inten_w > ram_rdata[CELL_W-1:0]) ? inten_w
                                                              : ram_rdata[CELL_W-1:0]};
      else
         upd_word = {1'b1, sum33[CELL_W] ? CELL_MAX : sum33[CELL_W-1:0]};
   end

   logic hit_ff;

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff       <= req_ch.x;
         y_ff       <= req_ch.y;
         inten_ff   <= req_ch.intensity;
         is_read_ff <= (cmd_type'(req_ch.cmd) == CMD_READ);
         inrange_ff <= (32'(req_ch.ring_sel) < 32'(rings_eff)) &&
                       (32'(req_ch.sector_sel) < 32'(sectors_eff));
         addr_ff    <= rd_addr[AW-1:0];
      end
      unique case (state_ff)
         ST_SQUARE: begin
            xx_ff   <= 32'(32'(x_ff) * 32'(x_ff));
            yy_ff   <= 32'(32'(y_ff) * 32'(y_ff));
            px_ff   <= CPW'({ax, 24'd0});
            py_ff   <= CPW'({ay, 24'd0});
            z_ff    <= '0;
            step_ff <= '0;
         end
         ST_RANGE: begin
            target_ff <= TW'(r2) * TW'(rr2_ff);
            sq_ff     <= TW'(mr2_ff);
            dsq_ff    <= TW'(mr2_ff) * TW'(3);
            k_ff      <= RW'(1);
         end
         ST_CORDIC: begin
            if (py_ff > 0) begin
               px_ff <= px_ff + py_sh;
               py_ff <= py_ff - px_sh;
               z_ff  <= z_ff + atan_s;
            end else begin
               px_ff <= px_ff - py_sh;
               py_ff <= py_ff + px_sh;
               z_ff  <= z_ff - atan_s;
            end
            step_ff <= step_ff + 1'b1;
         end
         ST_RING: begin
            if (!ring_done) begin
               sq_ff  <= sq_ff + dsq_ff;
               dsq_ff <= dsq_ff + (TW'(mr2_ff) << 1);
               k_ff   <= k_ff + 1'b1;
            end
         end
         ST_SECTOR: mul_ff  <= 48'(angle) * 48'(sectors_eff);
         ST_ADDR:   addr_ff <= pt_addr[AW-1:0];
         ST_SCALE: begin
            hit_ff <= ram_rdata[CELL_W] & inrange_ff;
            mul_ff <= ram_rdata[CELL_W-1:0] * scale_recip_ff;
         end
         default: ;
      endcase
   end

   // Cell memory: occupied flag over the 32-bit cell value
   pgdb_ram #(.WIDTH(WW), .DEPTH(NUM_CELLS)) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   // Response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] cell_value_ff;
   logic                    cell_empty_ff;

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      if (out_load) begin
         cell_empty_ff <= !hit_ff;
         if (hit_ff) cell_value_ff <= mul_ff[OUT_W-1] ? OUT_MAX : mul_ff;
         else        cell_value_ff <= OUT_W'(signed'(empty_value_ff));
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cell_value = cell_value_ff;
   assign rsp_ch.cell_empty = cell_empty_ff;
endmodule

// File: src/pgdb_checker.sv
// Port-level assertions of the binner and their bind to the top level.
module pgdb_checker import pgdb_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic [CMD_W-1:0]        req_cmd,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [OUT_W-1:0] rsp_cell_value,
   input logic                    rsp_cell_empty
);
   // A stalled response stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // An occupied cell never reads negative
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cell_empty |-> !rsp_cell_value[OUT_W-1])
      else $error("negative value for an occupied cell");

   // After reset the clearing pass holds off requests
   assert property (@(posedge clock) $past(reset) |-> !req_ready)
      else $error("request taken during the clearing pass");

   // A clear request starts a sweep that blocks requests
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_CLEAR) |=> !req_ready)
      else $error("request taken during a clear");
endmodule

bind polar_grid_descriptor_binner pgdb_checker u_pgdb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_cmd        (req_ch.cmd),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_cell_value (rsp_ch.cell_value),
   .rsp_cell_empty (rsp_ch.cell_empty)
);
